// File: src/multi_channel_pwm_runt_suppress_unit_assert.svh
// Assertion macros for the PWM unit. Each check is clocked on clk and is
// switched off while rst is high.
`ifndef MULTI_CHANNEL_PWM_RUNT_SUPPRESS_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_PWM_RUNT_SUPPRESS_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every edge.
`define MCPWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define MCPWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MCPWM_ASSERT(label, prop, msg)
`define MCPWM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: src/mcpwm_pkg.sv
`timescale 1ns / 1ps

package mcpwm_pkg;

  // Timer quanta of 4 us in one millisecond.
  localparam int unsigned QUANTA_PER_MS = 1000 / 4;
  // A duty of this many percent or more is steady on.
  localparam int unsigned PERCENT_FULL = 100;
  // Pulses shorter than this many counts are suppressed.
  localparam int unsigned RUNT_LIMIT = 25;

  // period * pct / 100 = pwm_period * pct * 250 / 100 = pwm_period * pct * 5 / 2.
  // The scale factor is exact because 2 * 250 is a multiple of 100.
  localparam int unsigned DUTY_SHIFT = 1;
  localparam int unsigned DUTY_NUM = (QUANTA_PER_MS << DUTY_SHIFT) / PERCENT_FULL;

  localparam int unsigned NUM_CHANNELS_DEFAULT = 6;

  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned CHANNEL_W = 3;
  localparam int unsigned PERCENT_W = 8;
  localparam int unsigned COUNT_W = 16;

  // Request kinds.
  typedef enum logic [0:0] {
    REQ_SET  = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

endpackage

// File: src/mcpwm_duty.sv
`timescale 1ns / 1ps

// Converts a duty percentage into a compare count, with runt suppression.
module mcpwm_duty (
  input  logic [mcpwm_pkg::PERIOD_W-1:0]  pwm_period,
  input  logic [mcpwm_pkg::PERCENT_W-1:0] duty_percent,
  output logic [mcpwm_pkg::COUNT_W-1:0]   period_count,
  output logic [mcpwm_pkg::COUNT_W-1:0]   compare_count
);

  logic [6:0]  pct_small;
  logic [14:0] prod;
  logic [17:0] scaled;
  logic [17:0] raw;
  logic [17:0] period_wide;

  // Period in timer quanta.
  assign period_count = 16'(16'(pwm_period) * 16'(mcpwm_pkg::QUANTA_PER_MS));
  assign period_wide  = 18'(period_count);

  // Only percentages below 100 reach the scaled path, so seven bits suffice.
  assign pct_small = duty_percent[6:0];
  assign prod      = 15'(pwm_period) * 15'(pct_small);
  assign scaled    = 18'(prod) * 18'(mcpwm_pkg::DUTY_NUM);
  assign raw       = scaled >> mcpwm_pkg::DUTY_SHIFT;

  // Off, fully on, or the scaled count with short pulses forced to a rail.
  always_comb begin
    priority if (duty_percent == '0) begin
      compare_count = '0;
    end else if (duty_percent >= 8'(mcpwm_pkg::PERCENT_FULL)) begin
      compare_count = period_count;
    end else if (raw < 18'(mcpwm_pkg::RUNT_LIMIT)) begin
      compare_count = '0;
    end else if (raw + 18'(mcpwm_pkg::RUNT_LIMIT) > period_wide) begin
      compare_count = period_count;
    end else begin
      compare_count = raw[15:0];
    end
  end

endmodule

// File: src/multi_channel_pwm_runt_suppress_unit.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   req_type, channel, duty_percent
// out       output     out_valid / out_stall pwm_levels, applied_count
// cfg       input      cfg_we                cfg_wdata (period in ms)
//
// One request enters every cycle unless a stalled result holds the input register.
// A request waits in the input register, and the duty conversion, counter step and
// compare loads happen as it moves into the result register.
// A stalled result holds the input register, which then stalls the input side.
// rst is synchronous and clears the period, counter, compare values and pending flags.
`timescale 1ns / 1ps

module multi_channel_pwm_runt_suppress_unit #(
  parameter int unsigned NUM_CHANNELS = mcpwm_pkg::NUM_CHANNELS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [mcpwm_pkg::CHANNEL_W-1:0]   channel,
  input  logic [mcpwm_pkg::PERCENT_W-1:0]   duty_percent,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [NUM_CHANNELS-1:0]           pwm_levels,
  output logic [mcpwm_pkg::COUNT_W-1:0]     applied_count,
  input  logic                              cfg_we,
  input  logic [mcpwm_pkg::PERIOD_W-1:0]    cfg_wdata
);

`include "multi_channel_pwm_runt_suppress_unit_assert.svh"

  // Configuration and timer state.
  logic [mcpwm_pkg::PERIOD_W-1:0]    pwm_period;
  logic [mcpwm_pkg::COUNT_W-1:0]     period_counter;
  logic [mcpwm_pkg::COUNT_W-1:0]     period_counter_next;
  logic [mcpwm_pkg::COUNT_W-1:0]     active_compare [NUM_CHANNELS];
  logic [mcpwm_pkg::COUNT_W-1:0]     active_compare_next [NUM_CHANNELS];
  logic [mcpwm_pkg::COUNT_W-1:0]     pending_compare [NUM_CHANNELS];
  logic [mcpwm_pkg::COUNT_W-1:0]     pending_compare_next [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]           pending_valid;
  logic [NUM_CHANNELS-1:0]           pending_valid_next;

  // Input register.
  logic                              s1_valid;
  mcpwm_pkg::req_t                   s1_req;
  logic [mcpwm_pkg::CHANNEL_W-1:0]   s1_channel;
  logic [mcpwm_pkg::PERCENT_W-1:0]   s1_percent;

  logic                              in_accept;
  logic                              advance;
  logic [mcpwm_pkg::COUNT_W-1:0]     period_count;
  logic [mcpwm_pkg::COUNT_W-1:0]     compare_count;
  logic [mcpwm_pkg::COUNT_W-1:0]     applied_next;
  logic [NUM_CHANNELS-1:0]           levels_next;
  logic                              at_boundary;

  // The held request moves on when the result register is free or being taken.
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req     <= mcpwm_pkg::req_t'(req_type);
      s1_channel <= channel;
      s1_percent <= duty_percent;
    end
  end

  mcpwm_duty u_duty (
    .pwm_period    (pwm_period),
    .duty_percent  (s1_percent),
    .period_count  (period_count),
    .compare_count (compare_count)
  );

  // The counter wraps at the end of the period, and at once when the period is zero.
  assign at_boundary = (period_count == '0) ||
                       (17'(period_counter) + 17'd1 >= 17'(period_count));

  // Next timer state for the held request.
  always_comb begin
    period_counter_next  = period_counter;
    active_compare_next  = active_compare;
    pending_compare_next = pending_compare;
    pending_valid_next   = pending_valid;
    applied_next         = '0;
    unique case (s1_req)
      mcpwm_pkg::REQ_SET: begin
        applied_next = compare_count;
        for (int n = 0; n < NUM_CHANNELS; n++) begin
          if (s1_channel == mcpwm_pkg::CHANNEL_W'(n)) begin
            pending_compare_next[n] = compare_count;
            pending_valid_next[n]   = 1'b1;
          end
        end
      end
      mcpwm_pkg::REQ_TICK: begin
        if (at_boundary) begin
          period_counter_next = '0;
          for (int n = 0; n < NUM_CHANNELS; n++) begin
            if (pending_valid[n]) begin
              active_compare_next[n] = pending_compare[n];
            end
          end
          pending_valid_next = '0;
        end else begin
          period_counter_next = period_counter + 16'd1;
        end
      end
      default: begin
        applied_next = '0;
      end
    endcase
  end

  // Channel levels after this request.
  always_comb begin
    for (int n = 0; n < NUM_CHANNELS; n++) begin
      levels_next[n] = period_counter_next < active_compare_next[n];
    end
  end

  // Period register and counter; a period write restarts the counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period     <= '0;
      period_counter <= '0;
    end else if (cfg_we) begin
      pwm_period     <= cfg_wdata;
      period_counter <= '0;
    end else if (advance) begin
      period_counter <= period_counter_next;
    end
  end

  // Compare registers and pending flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= '0;
      for (int n = 0; n < NUM_CHANNELS; n++) begin
        active_compare[n]  <= '0;
        pending_compare[n] <= '0;
      end
    end else if (advance) begin
      pending_valid   <= pending_valid_next;
      active_compare  <= active_compare_next;
      pending_compare <= pending_compare_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pwm_levels    <= levels_next;
      applied_count <= applied_next;
    end
  end

  // The counter never runs past the end of a nonzero period.
  `MCPWM_ASSERT(a_counter_in_period,
                (period_counter == '0) || (period_counter < period_count),
                "period counter outside period")
  // A tick that reaches the boundary leaves no load pending.
  `MCPWM_ASSERT_NEXT(a_boundary_loads,
                     advance && (s1_req == mcpwm_pkg::REQ_TICK) && at_boundary,
                     pending_valid == '0, "pending compare not loaded at boundary")
  // Every request that moves on produces a result.
  `MCPWM_ASSERT_NEXT(a_advance_result, advance, out_valid, "request advanced without a result")

endmodule

// File: sim/multi_channel_pwm_runt_suppress_unit_tb.sv
`timescale 1ns / 1ps

module multi_channel_pwm_runt_suppress_unit_tb;

  localparam int unsigned NCH = mcpwm_pkg::NUM_CHANNELS_DEFAULT;
  // Cycles allowed after the last result before the period is rewritten or the run ends.
  localparam int unsigned SETTLE_CYCLES = 4;

  // One result: channel levels and the compare count of a set request.
  typedef struct packed {
    logic [NCH-1:0]                levels;
    logic [mcpwm_pkg::COUNT_W-1:0] count;
  } pwm_out_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  // One directed step. A configuration row carries the new period in duty.
  typedef struct packed {
    row_kind_t                       kind;
    mcpwm_pkg::req_t                 req;
    logic [mcpwm_pkg::CHANNEL_W-1:0] chan;
    logic [mcpwm_pkg::PERCENT_W-1:0] duty;
    logic                            typed_out;
    logic [NCH-1:0]                  levels;
    logic [mcpwm_pkg::COUNT_W-1:0]   count;
  } step_row_t;

  // Extremes, runt suppression on both sides, out-of-range channels,
  // zero period loads and the period boundary.
  localparam step_row_t DIRECTED [25] = '{
    '{ROW_REQ, mcpwm_pkg::REQ_TICK, 3'd0, 8'd0,   1'b1, 6'd0, 16'd0},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd0, 8'd100, 1'b1, 6'd0, 16'd0},
    '{ROW_REQ, mcpwm_pkg::REQ_TICK, 3'd0, 8'd0,   1'b1, 6'd0, 16'd0},
    '{ROW_CFG, mcpwm_pkg::REQ_SET,  3'd0, 8'd255, 1'b0, 6'd0, 16'd0},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd1, 8'd100, 1'b1, 6'd0, 16'd63750},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd2, 8'd1,   1'b1, 6'd0, 16'd637},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd3, 8'd99,  1'b1, 6'd0, 16'd63112},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd7, 8'd255, 1'b1, 6'd0, 16'd63750},
    '{ROW_REQ, mcpwm_pkg::REQ_TICK, 3'd0, 8'd0,   1'b0, 6'd0, 16'd0},
    '{ROW_CFG, mcpwm_pkg::REQ_SET,  3'd0, 8'd1,   1'b0, 6'd0, 16'd0},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd0, 8'd0,   1'b1, 6'd0, 16'd0},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd1, 8'd5,   1'b1, 6'd0, 16'd0},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd2, 8'd95,  1'b1, 6'd0, 16'd250},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd3, 8'd50,  1'b1, 6'd0, 16'd125},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd4, 8'd10,  1'b1, 6'd0, 16'd25},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd5, 8'd90,  1'b1, 6'd0, 16'd225},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd6, 8'd50,  1'b1, 6'd0, 16'd125},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd4, 8'd9,   1'b0, 6'd0, 16'd0},
    '{ROW_REQ, mcpwm_pkg::REQ_TICK, 3'd7, 8'd255, 1'b0, 6'd0, 16'd0},
    '{ROW_CFG, mcpwm_pkg::REQ_SET,  3'd0, 8'd0,   1'b0, 6'd0, 16'd0},
    '{ROW_REQ, mcpwm_pkg::REQ_TICK, 3'd0, 8'd0,   1'b0, 6'd0, 16'd0},
    '{ROW_REQ, mcpwm_pkg::REQ_SET,  3'd5, 8'd37,  1'b0, 6'd0, 16'd0},
    '{ROW_REQ, mcpwm_pkg::REQ_TICK, 3'd0, 8'd0,   1'b0, 6'd0, 16'd0},
    '{ROW_CFG, mcpwm_pkg::REQ_SET,  3'd0, 8'd1,   1'b0, 6'd0, 16'd0},
    '{ROW_REQ, mcpwm_pkg::REQ_TICK, 3'd0, 8'd0,   1'b0, 6'd0, 16'd0}
  };

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  mcpwm_pkg::req_t                 req_type = mcpwm_pkg::REQ_SET;
  logic [mcpwm_pkg::CHANNEL_W-1:0] channel = '0;
  logic [mcpwm_pkg::PERCENT_W-1:0] duty_percent = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [NCH-1:0]                  pwm_levels;
  logic [mcpwm_pkg::COUNT_W-1:0]   applied_count;
  logic                            cfg_we = 1'b0;
  logic [mcpwm_pkg::PERIOD_W-1:0]  cfg_wdata = '0;

  // Shadow of the timer state, kept in step with accepted requests.
  int unsigned pwm_period_q = 0;
  int unsigned count_pos = 0;
  int unsigned live_cmp [NCH] = '{default: 0};
  int unsigned queued_cmp [NCH] = '{default: 0};
  bit          queued_ok [NCH] = '{default: 1'b0};

  pwm_out_t    due_outputs[$];
  int unsigned mismatches = 0;
  int unsigned src_gap_pct = 0;
  int unsigned sink_stall_pct = 0;

  multi_channel_pwm_runt_suppress_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .channel      (channel),
    .duty_percent (duty_percent),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pwm_levels   (pwm_levels),
    .applied_count(applied_count),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Convert a duty percentage to a compare count with runt suppression.
  function automatic int unsigned duty_counts(input int unsigned pct);
    int unsigned span;
    int unsigned c;
    span = pwm_period_q * mcpwm_pkg::QUANTA_PER_MS;
    if (pct == 0) return 0;
    if (pct >= mcpwm_pkg::PERCENT_FULL) return span;
    c = span * pct / mcpwm_pkg::PERCENT_FULL;
    if (c < mcpwm_pkg::RUNT_LIMIT) return 0;
    if (c + mcpwm_pkg::RUNT_LIMIT > span) return span;
    return c;
  endfunction

  // Apply one request to the shadow state and return the result it causes.
  task automatic advance_timer(input mcpwm_pkg::req_t rq,
                               input logic [mcpwm_pkg::CHANNEL_W-1:0] chan,
                               input logic [mcpwm_pkg::PERCENT_W-1:0] duty,
                               output pwm_out_t res);
    int unsigned applied;
    int unsigned span;
    applied = 0;
    if (rq == mcpwm_pkg::REQ_SET) begin
      applied = duty_counts(duty);
      if (chan < NCH) begin
        queued_cmp[chan] = applied;
        queued_ok[chan] = 1'b1;
      end
    end else begin
      span = pwm_period_q * mcpwm_pkg::QUANTA_PER_MS;
      // A wrap, or any tick with a zero period, loads the pending compares.
      if (span == 0 || count_pos + 1 >= span) begin
        count_pos = 0;
        for (int n = 0; n < NCH; n++) begin
          if (queued_ok[n]) begin
            live_cmp[n] = queued_cmp[n];
            queued_ok[n] = 1'b0;
          end
        end
      end else begin
        count_pos++;
      end
    end
    for (int n = 0; n < NCH; n++) res.levels[n] = (count_pos < live_cmp[n]);
    res.count = applied[mcpwm_pkg::COUNT_W-1:0];
  endtask

  // Present one request, hold it until accepted, then record its expected result.
  task automatic send_request(input mcpwm_pkg::req_t rq,
                              input logic [mcpwm_pkg::CHANNEL_W-1:0] chan,
                              input logic [mcpwm_pkg::PERCENT_W-1:0] duty,
                              input logic use_typed, input pwm_out_t typed_val);
    pwm_out_t guess;
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    channel <= chan;
    duty_percent <= duty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_timer(rq, chan, duty, guess);
    due_outputs.push_back(use_typed ? typed_val : guess);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Rewrite the period while the block is idle; this also clears the counter.
  task automatic write_period(input logic [mcpwm_pkg::PERIOD_W-1:0] ms);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    pwm_period_q = ms;
    count_pos = 0;
    @(posedge clk);
  endtask

  // Random back-pressure on the result side.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin
    pwm_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_outputs.size() == 0) begin
        $display("%0t: result with none expected, levels %b count %0d", $time,
                 pwm_levels, applied_count);
        mismatches++;
      end else begin
        want = due_outputs.pop_front();
        if (pwm_levels !== want.levels) begin
          $display("%0t: pwm_levels expected %b actual %b", $time, want.levels,
                   pwm_levels);
          mismatches++;
        end
        if (applied_count !== want.count) begin
          $display("%0t: applied_count expected %0d actual %0d", $time, want.count,
                   applied_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    step_row_t                       row;
    mcpwm_pkg::req_t                 rq;
    logic [mcpwm_pkg::CHANNEL_W-1:0] chan;
    logic [mcpwm_pkg::PERCENT_W-1:0] duty;
    logic [mcpwm_pkg::PERIOD_W-1:0]  ms;
    int unsigned                     seg_len;
    int unsigned                     tick_share;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    src_gap_pct = 7;
    sink_stall_pct = 64;
    @(posedge clk);

    // Directed requests.
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        write_period(row.duty);
      end else begin
        send_request(row.req, row.chan, row.duty, row.typed_out, {row.levels, row.count});
      end
    end

    // Random requests, three idling profiles, each over zero, short and long periods.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_gap_pct = 7;
          sink_stall_pct = 64;
        end
        1: begin
          src_gap_pct = 64;
          sink_stall_pct = 7;
        end
        default: begin
          src_gap_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        // The one-millisecond period is tick heavy so that it wraps and loads compares.
        case (seg)
          0: begin
            ms = '0;
            seg_len = 80;
            tick_share = 50;
          end
          1: begin
            ms = 8'd1;
            seg_len = 450;
            tick_share = 88;
          end
          default: begin
            ms = (phase == 0) ? 8'd255 : 8'($urandom_range(2, 255));
            seg_len = 120;
            tick_share = 60;
          end
        endcase
        write_period(ms);
        repeat (seg_len) begin
          if ($urandom_range(0, 199) == 0) drain_results();
          rq = ($urandom_range(0, 99) < tick_share) ? mcpwm_pkg::REQ_TICK
                                                    : mcpwm_pkg::REQ_SET;
          chan = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
          // Weight the duty toward both runt thresholds and the full-on limit.
          case ($urandom_range(0, 3))
            0: duty = 8'($urandom_range(0, 255));
            1: duty = 8'($urandom_range(0, 12));
            2: duty = 8'($urandom_range(85, 100));
            default: duty = 8'($urandom_range(0, 100));
          endcase
          send_request(rq, chan, duty, 1'b0, '0);
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("multi_channel_pwm_runt_suppress_unit_tb passed");
    end else begin
      $display("multi_channel_pwm_runt_suppress_unit_tb failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("multi_channel_pwm_runt_suppress_unit_tb failed");
    $finish;
  end

endmodule
